[hdl/atcmd_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the AT command line recogniser.
// Holds the command name table; it depends on nothing else.
package atcmd_pkg;

  localparam int TABLE_SIZE           = 23;
  localparam int NAME_MAX_LEN         = 10;
  localparam int DEFAULT_MAX_LINE     = 1024;
  localparam int DEFAULT_NUM_COMMANDS = 23;

  localparam int BYTE_W     = 8;
  localparam int INDEX_W    = 5;
  localparam int NAME_LEN_W = 4;
  localparam int LINE_LEN_W = 11;

  localparam logic [BYTE_W-1:0] CH_CR       = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_EQ       = 8'h3D;
  localparam logic [BYTE_W-1:0] CH_NUL      = 8'h00;
  localparam logic [BYTE_W-1:0] CH_A_UPPER  = 8'h41;
  localparam logic [BYTE_W-1:0] CH_A_LOWER  = 8'h61;
  localparam logic [BYTE_W-1:0] CH_T_UPPER  = 8'h54;
  localparam logic [BYTE_W-1:0] CH_T_LOWER  = 8'h74;
  localparam logic [BYTE_W-1:0] CH_LC_FIRST = 8'h61;
  localparam logic [BYTE_W-1:0] CH_LC_LAST  = 8'h7A;
  localparam logic [BYTE_W-1:0] CASE_OFFSET = 8'h20;

  typedef logic [NAME_MAX_LEN*BYTE_W-1:0] name_t;

  // Names are held already folded to upper case, right-justified, first character highest.
  localparam name_t NAME_TAB [TABLE_SIZE] = '{
    "AT", "+SENDMSG", "+MALLOC", "+FILEOPEN", "+FILEREAD", "+FILEWRITE",
    "+FILESEEK", "+FILECLOSE", "+GB2UI", "+GPIOCFG", "+GPIOSET", "+GPIOGET",
    "+LPGCTRL", "+PINIRQ", "+PDP", "+TCP", "+TCPSEND", "+UDP", "+UDPSEND",
    "+VER", "+AT", "+FILECLEAR", "+MQTTPUB"
  };

  localparam logic [NAME_LEN_W-1:0] NAME_LEN [TABLE_SIZE] = '{
    4'd2, 4'd8, 4'd7, 4'd9, 4'd9, 4'd10, 4'd9, 4'd10, 4'd6, 4'd8, 4'd8, 4'd8,
    4'd8, 4'd7, 4'd4, 4'd4, 4'd8, 4'd4, 4'd8, 4'd4, 4'd3, 4'd10, 4'd8
  };

  typedef enum logic [3:0] {
    PH_HUNT    = 4'b0001,
    PH_GOT_A   = 4'b0010,
    PH_GOT_T   = 4'b0100,
    PH_COLLECT = 4'b1000
  } phase_t;

  typedef struct packed {
    logic                  found;
    logic [INDEX_W-1:0]    index;
    logic [NAME_LEN_W-1:0] name_len;
    logic [LINE_LEN_W-1:0] line_len;
    logic                  overflow;
  } result_t;

  function automatic logic [BYTE_W-1:0] fold_upper(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] r;
    r = c;
    if (c >= CH_LC_FIRST && c <= CH_LC_LAST) begin
      r = c - CASE_OFFSET;
    end
    return r;
  endfunction

  // Character at position p of table entry e; zero beyond the end of the name.
  function automatic logic [BYTE_W-1:0] name_char(input int e, input logic [3:0] p);
    logic [BYTE_W-1:0] ch;
    int                sh;
    ch = CH_NUL;
    sh = 0;
    if (p < NAME_LEN[e]) begin
      sh = (int'(NAME_LEN[e]) - 1 - int'(p)) * BYTE_W;
      ch = NAME_TAB[e][sh +: BYTE_W];
    end
    return ch;
  endfunction

endpackage

[hdl/at_command_line_recognizer.sv]
`timescale 1ns / 1ps
// AT command line recogniser: takes one received byte per cycle while byte_stall is low
// and reports one result per completed line. Uses atcmd_pkg for the name table, the phase
// type and the result record.
// The block accepts one byte in every cycle in which byte_stall is low. A byte is first
// held in an input register; from there it updates the prefix hunt, the line count and one
// alive bit per table name; the carriage return ending a line registers its result.
// The result register is backed by a one-entry skid register, so bytes keep
// flowing while a result waits; byte_stall rises only when both hold a result that the
// receiver has not yet taken. Lines longer than MAX_LINE saturate the count and set
// line_overflow, and only the first NUM_COMMANDS table entries (at most 23) are searched.
module at_command_line_recognizer #(
  parameter int MAX_LINE     = atcmd_pkg::DEFAULT_MAX_LINE,
  parameter int NUM_COMMANDS = atcmd_pkg::DEFAULT_NUM_COMMANDS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              byte_valid,
  output logic                              byte_stall,
  input  logic [atcmd_pkg::BYTE_W-1:0]      byte_value,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic                              command_found,
  output logic [atcmd_pkg::INDEX_W-1:0]     command_index,
  output logic [atcmd_pkg::NAME_LEN_W-1:0]  name_length,
  output logic [atcmd_pkg::LINE_LEN_W-1:0]  line_length,
  output logic                              line_overflow
);
  import atcmd_pkg::*;

  localparam int COUNT_W    = $clog2(MAX_LINE + 1);
  localparam int NUM_ACTIVE = (NUM_COMMANDS > TABLE_SIZE) ? TABLE_SIZE : NUM_COMMANDS;

  // Parser state.
  phase_t                 phase, phase_next;
  logic [COUNT_W-1:0]     count, count_next;
  logic [TABLE_SIZE-1:0]  alive, alive_next;
  logic                   ovf_seen, ovf_next;

  // Input register.
  logic                   in_v;
  logic [BYTE_W-1:0]      in_q;

  // Result register and skid register.
  result_t                main_res, skid_res, res_new;
  logic                   skid_valid;

  logic                   proc, emit, take;
  logic                   is_a, is_t, is_cr;
  logic [BYTE_W-1:0]      folded;
  logic [TABLE_SIZE-1:0]  keep;
  logic                   at_max;
  logic [COUNT_W-1:0]     col_count;
  logic [TABLE_SIZE-1:0]  col_alive;
  logic                   col_ovf;
  logic                   hit_found;
  logic [INDEX_W-1:0]     hit_index;
  logic [NAME_LEN_W-1:0]  hit_len;

  assign byte_stall = skid_valid;
  assign proc       = in_v && !skid_valid;
  assign take       = result_valid && !result_stall;

  assign folded = fold_upper(in_q);
  assign is_a   = (in_q == CH_A_UPPER) || (in_q == CH_A_LOWER);
  assign is_t   = (in_q == CH_T_UPPER) || (in_q == CH_T_LOWER);
  assign is_cr  = (in_q == CH_CR);
  assign at_max = (count == COUNT_W'(MAX_LINE));

  // Per-name compare of the byte at the current line position.
  always_comb begin
    for (int e = 0; e < TABLE_SIZE; e++) begin
      if (count < COUNT_W'(NAME_LEN[e])) begin
        keep[e] = (folded == name_char(e, count[3:0]));
      end else if (count == COUNT_W'(NAME_LEN[e])) begin
        keep[e] = (in_q == CH_EQ) || (in_q == CH_NUL);
      end else begin
        keep[e] = 1'b1;
      end
    end
  end

  // Once the line is full, further bytes are dropped and only the overflow flag moves.
  always_comb begin
    if (at_max) begin
      col_count = count;
      col_alive = alive;
      col_ovf   = 1'b1;
    end else begin
      col_count = count + COUNT_W'(1);
      col_alive = alive & keep;
      col_ovf   = ovf_seen;
    end
  end

  // Lowest-numbered surviving name that the line was long enough to contain.
  always_comb begin
    hit_found = 1'b0;
    hit_index = '0;
    hit_len   = '0;
    for (int e = NUM_ACTIVE - 1; e >= 0; e--) begin
      if (alive[e] && (count >= COUNT_W'(NAME_LEN[e]))) begin
        hit_found = 1'b1;
        hit_index = INDEX_W'(e);
        hit_len   = NAME_LEN[e];
      end
    end
  end

  always_comb begin
    phase_next = phase;
    count_next = count;
    alive_next = alive;
    ovf_next   = ovf_seen;
    emit       = 1'b0;
    res_new    = '0;
    if (proc) begin
      case (phase)
        PH_HUNT: begin
          if (is_a) begin
            phase_next = PH_GOT_A;
          end
        end
        PH_GOT_A: begin
          if (is_t) begin
            phase_next = PH_GOT_T;
          end else if (!is_a) begin
            phase_next = PH_HUNT;
          end
        end
        PH_GOT_T: begin
          if (is_cr) begin
            emit             = 1'b1;
            res_new.found    = 1'b1;
            res_new.index    = '0;
            res_new.name_len = NAME_LEN[0];
            res_new.line_len = LINE_LEN_W'(2);
            res_new.overflow = 1'b0;
            phase_next       = PH_HUNT;
          end else begin
            phase_next = PH_COLLECT;
            count_next = col_count;
            alive_next = col_alive;
            ovf_next   = col_ovf;
          end
        end
        PH_COLLECT: begin
          if (is_cr) begin
            emit             = 1'b1;
            res_new.found    = hit_found;
            res_new.index    = hit_index;
            res_new.name_len = hit_len;
            res_new.line_len = LINE_LEN_W'(count);
            res_new.overflow = ovf_seen;
            phase_next       = PH_HUNT;
            count_next       = '0;
            alive_next       = '1;
            ovf_next         = 1'b0;
          end else begin
            count_next = col_count;
            alive_next = col_alive;
            ovf_next   = col_ovf;
          end
        end
        default: begin
          phase_next = PH_HUNT;
          count_next = '0;
          alive_next = '1;
          ovf_next   = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      count        <= '0;
      alive        <= '1;
      ovf_seen     <= 1'b0;
      in_v         <= 1'b0;
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else begin
      phase    <= phase_next;
      count    <= count_next;
      alive    <= alive_next;
      ovf_seen <= ovf_next;
      if (!skid_valid) begin
        in_v <= byte_valid;
      end
      if (skid_valid) begin
        if (take) begin
          skid_valid <= 1'b0;
        end
      end else if (emit) begin
        if (result_valid && !take) begin
          skid_valid <= 1'b1;
        end else begin
          result_valid <= 1'b1;
        end
      end else if (take) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid) begin
      in_q <= byte_value;
    end
    if (skid_valid) begin
      if (take) begin
        main_res <= skid_res;
      end
    end else if (emit) begin
      if (result_valid && !take) begin
        skid_res <= res_new;
      end else begin
        main_res <= res_new;
      end
    end
  end

  assign command_found = main_res.found;
  assign command_index = main_res.index;
  assign name_length   = main_res.name_len;
  assign line_length   = main_res.line_len;
  assign line_overflow = main_res.overflow;

  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid register holds a result while the output register is empty");

  a_count_saturates: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(MAX_LINE))
    else $error("line count went past the maximum line length");

  a_overflow_at_max: assert property (@(posedge clk) disable iff (rst)
    ovf_seen |-> at_max)
    else $error("overflow flag set while the line count is below the maximum");

  a_idle_state_clear: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_COLLECT) |-> (count == '0 && alive == '1 && !ovf_seen))
    else $error("line state not cleared outside the collecting phase");

  a_found_in_range: assert property (@(posedge clk) disable iff (rst)
    (result_valid && command_found) |->
      (name_length != '0 && command_index < INDEX_W'(NUM_ACTIVE)))
    else $error("reported command lies outside the searched table entries");

endmodule

[tb/at_command_line_recognizer_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the AT command line recogniser: a queue-fed byte driver, a result
// monitor and a byte-level line predictor. Depends on atcmd_pkg and the block itself.
module at_command_line_recognizer_tb;
  import atcmd_pkg::*;

  localparam int MAX_LINE_TB  = DEFAULT_MAX_LINE;
  localparam int NUM_CMDS     = (DEFAULT_NUM_COMMANDS > TABLE_SIZE) ? TABLE_SIZE
                                                                      : DEFAULT_NUM_COMMANDS;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 10;
  localparam int PHASE_BYTES  = 150;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  byte_valid = 1'b0;
  logic                  byte_stall;
  logic [BYTE_W-1:0]     byte_value = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  logic                  command_found;
  logic [INDEX_W-1:0]    command_index;
  logic [NAME_LEN_W-1:0] name_length;
  logic [LINE_LEN_W-1:0] line_length;
  logic                  line_overflow;

  // Command names as the line must spell them; matching ignores case.
  string cmd_names [TABLE_SIZE] = '{
    "AT", "+SENDMSG", "+MALLOC", "+FILEOPEN", "+FILEREAD", "+FILEWRITE",
    "+FILESEEK", "+FILECLOSE", "+GB2UI", "+GPIOCFG", "+GPIOSET", "+GPIOGET",
    "+LPGCTRL", "+PINIRQ", "+PDP", "+TCP", "+TCPSEND", "+UDP", "+UDPSEND",
    "+VER", "+AT", "+FILECLEAR", "+MQTTPUB"
  };

  logic [BYTE_W-1:0] tx_backlog [$];
  result_t           expected_lines [$];
  int                error_count = 0;
  int                cycle_count = 0;
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;

  // Predictor state for the line being parsed.
  phase_t                line_phase = PH_HUNT;
  int                    collected = 0;
  logic [TABLE_SIZE-1:0] alive = '1;
  logic                  ovf_seen = 1'b0;

  at_command_line_recognizer uut (
    .clk           (clk),
    .rst           (rst),
    .byte_valid    (byte_valid),
    .byte_stall    (byte_stall),
    .byte_value    (byte_value),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .command_found (command_found),
    .command_index (command_index),
    .name_length   (name_length),
    .line_length   (line_length),
    .line_overflow (line_overflow)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [BYTE_W-1:0] upcase(input logic [BYTE_W-1:0] c);
    if (c >= 8'h61 && c <= 8'h7A) begin
      return c - 8'h20;
    end
    return c;
  endfunction

  task automatic clear_line();
    line_phase = PH_HUNT;
    collected  = 0;
    alive      = '1;
    ovf_seen   = 1'b0;
  endtask

  task automatic collect_byte(input logic [BYTE_W-1:0] c);
    int   len;
    logic keep;
    if (collected >= MAX_LINE_TB) begin
      ovf_seen = 1'b1;
    end else begin
      for (int e = 0; e < TABLE_SIZE; e++) begin
        len  = cmd_names[e].len();
        keep = 1'b1;
        if (collected < len) begin
          keep = (upcase(cmd_names[e][collected]) == upcase(c));
        end else if (collected == len) begin
          keep = (c == CH_EQ) || (c == CH_NUL);
        end
        if (!keep) begin
          alive[e] = 1'b0;
        end
      end
      collected++;
    end
  endtask

  task automatic recognise_byte(input logic [BYTE_W-1:0] c, output logic got,
                                output result_t r);
    logic is_a;
    logic is_t;
    logic hit;
    is_a = (c == CH_A_UPPER) || (c == CH_A_LOWER);
    is_t = (c == CH_T_UPPER) || (c == CH_T_LOWER);
    got  = 1'b0;
    r    = '0;
    hit  = 1'b0;
    case (line_phase)
      PH_HUNT: begin
        if (is_a) begin
          line_phase = PH_GOT_A;
        end
      end
      PH_GOT_A: begin
        if (is_t) begin
          line_phase = PH_GOT_T;
        end else if (!is_a) begin
          clear_line();
        end
      end
      PH_GOT_T: begin
        if (c == CH_CR) begin
          // A bare prefix reports the first table entry.
          got        = 1'b1;
          r.found    = 1'b1;
          r.name_len = NAME_LEN_W'(cmd_names[0].len());
          r.line_len = LINE_LEN_W'(2);
          clear_line();
        end else begin
          line_phase = PH_COLLECT;
          collect_byte(c);
        end
      end
      default: begin
        if (c == CH_CR) begin
          for (int e = 0; e < NUM_CMDS; e++) begin
            if (!hit && alive[e] && collected >= cmd_names[e].len()) begin
              hit        = 1'b1;
              r.found    = 1'b1;
              r.index    = INDEX_W'(e);
              r.name_len = NAME_LEN_W'(cmd_names[e].len());
            end
          end
          got        = 1'b1;
          r.line_len = LINE_LEN_W'(collected);
          r.overflow = ovf_seen;
          clear_line();
        end else begin
          collect_byte(c);
        end
      end
    endcase
  endtask

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  // Byte driver: a stalled transaction holds its payload; otherwise the next byte goes out
  // unless the sender idles this cycle.
  always @(posedge clk) begin : drive_bytes
    logic    got;
    result_t r;
    if (rst) begin
      byte_valid <= 1'b0;
    end else begin
      if (byte_valid && !byte_stall) begin
        recognise_byte(byte_value, got, r);
        if (got) begin
          expected_lines.push_back(r);
        end
      end
      if (!(byte_valid && byte_stall)) begin
        if (tx_backlog.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          byte_value <= tx_backlog.pop_front();
          byte_valid <= 1'b1;
        end else begin
          byte_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch_results
    result_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_lines.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result: expected none, actual found=%0d index=%0d",
                   $time, command_found, command_index);
        end else begin
          want = expected_lines.pop_front();
          check_field("command_found", want.found, command_found);
          check_field("command_index", want.index, command_index);
          check_field("name_length", want.name_len, name_length);
          check_field("line_length", want.line_len, line_length);
          check_field("line_overflow", want.overflow, line_overflow);
        end
      end
      result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      tx_backlog.push_back(s[i]);
    end
  endtask

  function automatic logic [BYTE_W-1:0] mix_case(input logic [BYTE_W-1:0] c);
    if (upcase(c) >= 8'h41 && upcase(c) <= 8'h5A && $urandom_range(0, 1)) begin
      return c ^ 8'h20;
    end
    return c;
  endfunction

  function automatic logic [BYTE_W-1:0] payload_byte();
    logic [BYTE_W-1:0] c;
    c = BYTE_W'($urandom_range(0, 255));
    if (c == CH_CR) begin
      c = 8'h2C;
    end
    return c;
  endfunction

  task automatic push_prefix();
    tx_backlog.push_back(mix_case(CH_A_UPPER));
    tx_backlog.push_back(mix_case(CH_T_UPPER));
  endtask

  task automatic push_name(input int e, input int n);
    for (int i = 0; i < n; i++) begin
      tx_backlog.push_back(mix_case(cmd_names[e][i]));
    end
  endtask

  // Line of n collected bytes behind the prefix, for the saturation boundary.
  task automatic push_long_line(input int n);
    push_prefix();
    push_text("+MQTTPUB=");
    for (int i = 9; i < n; i++) begin
      tx_backlog.push_back(payload_byte());
    end
    tx_backlog.push_back(CH_CR);
  endtask

  task automatic push_random_line();
    int                kind;
    int                e;
    int                n;
    logic [BYTE_W-1:0] c;
    kind = $urandom_range(0, 99);
    e    = $urandom_range(0, TABLE_SIZE - 1);
    if (kind < 60) begin
      n = $urandom_range(0, 2);
      repeat (n) begin
        c = BYTE_W'($urandom_range(0, 255));
        if (upcase(c) == CH_A_UPPER) begin
          c = 8'h2E;
        end
        tx_backlog.push_back(c);
      end
      push_prefix();
      if ($urandom_range(0, 7) != 0) begin
        push_name(e, cmd_names[e].len());
        case ($urandom_range(0, 3))
          1: tx_backlog.push_back(CH_EQ);
          2: tx_backlog.push_back(CH_NUL);
          3: tx_backlog.push_back(payload_byte());
          default: ;
        endcase
        n = $urandom_range(0, 6);
        repeat (n) tx_backlog.push_back(payload_byte());
      end
    end else if (kind < 75) begin
      push_prefix();
      push_name(e, $urandom_range(1, cmd_names[e].len() - 1));
    end else if (kind < 90) begin
      n = $urandom_range(1, 12);
      repeat (n) tx_backlog.push_back(BYTE_W'($urandom_range(0, 255)));
    end else begin
      // A broken prefix followed by a proper line.
      tx_backlog.push_back(mix_case(CH_A_UPPER));
      tx_backlog.push_back(BYTE_W'($urandom_range(0, 255)));
      push_prefix();
      push_name(e, cmd_names[e].len());
    end
    tx_backlog.push_back(CH_CR);
  endtask

  task automatic wait_idle();
    while (tx_backlog.size() != 0 || byte_valid || expected_lines.size() != 0) begin
      @(negedge clk);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed lines: extremes of the byte, the bare prefix and the hunt corner cases.
    tx_backlog.push_back(8'h00);
    tx_backlog.push_back(8'hFF);
    tx_backlog.push_back(8'hE1);
    push_text("AT\r");
    push_text("at\r");
    push_text("AT+SENDMSG\r");
    push_text("at+sendmsg=1,2\r");
    push_text("AT+TCP");
    tx_backlog.push_back(CH_NUL);
    push_text("x\r");
    push_text("AT+TCPSEND\r");
    push_text("AT+SEND\r");
    push_text("AXAT\r");
    push_text("A\rAAT+AT\r");
    push_text("ATAT\r");
    push_text("AT+");
    tx_backlog.push_back(8'hD6);
    push_text("ER\r");
    push_text("AT+FILECLEAR=\r");
    push_text("At");
    tx_backlog.push_back(8'hFF);
    push_text("\r");
    push_text("aT=\r");
    wait_idle();

    // Each phase ends with the sender held back until every result has arrived.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      // One line just past the maximum reaches the saturated count and sets the overflow.
      if (phase == 0) begin
        push_long_line(MAX_LINE_TB + 1);
      end
      while (tx_backlog.size() < PHASE_BYTES) begin
        push_random_line();
      end
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
